// File: design/sha_pkg.sv
package sha_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_state_t;

	// Opcodes of the message channel
	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_FINISH = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;

	// Padding constants
	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS       = 6'd56;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam int         TOTAL_W       = 61;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
	} msg_req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_req_t;

	// Control from the sequencer to the round unit
	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       start;
	} core_ctrl_t;

	// Status from the round unit
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	// Initial hash values, word 0 in element 0
	localparam hash_state_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	// Round constants
	function automatic word_t round_k(input logic [5:0] idx);
		word_t k;
		unique case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

endpackage

// File: design/sha_core.sv
module sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::core_ctrl_t  ctrl,
	input  sha_pkg::hash_state_t hash_in,
	output sha_pkg::core_stat_t  stat,
	output sha_pkg::hash_state_t work
);
	import sha_pkg::*;

	// Block window: 16 words, oldest word at index 0
	word_t       w_q [16];
	hash_state_t work_q;
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        done_q;

	word_t       t1;
	word_t       t2;
	word_t       w_new;
	hash_state_t work_next;

	// One compression round and one schedule word per cycle
	always_comb begin
		t1 = work_q[7] + big_sigma1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ round_k(rnd_q) + w_q[0];
		t2 = big_sigma0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
		w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
		work_next[7] = work_q[6];
		work_next[6] = work_q[5];
		work_next[5] = work_q[4];
		work_next[4] = work_q[3] + t1;
		work_next[3] = work_q[2];
		work_next[2] = work_q[1];
		work_next[1] = work_q[0];
		work_next[0] = t1 + t2;
	end

	// Round sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == LAST_POS) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Window and working variables
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q <= hash_in;
		end else if (busy_q) begin
			work_q <= work_next;
		end
		if (ctrl.load) begin
			for (int k = 0; k < 15; k++) begin
				w_q[k] <= {w_q[k][23:0], w_q[k+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], ctrl.data};
		end else if (busy_q) begin
			for (int k = 0; k < 15; k++) begin
				w_q[k] <= w_q[k+1];
			end
			w_q[15] <= w_new;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign work      = work_q;

endmodule

// File: design/sha256_message_hasher.sv
// SHA-256 hasher, fed one request at a time on the msg channel.
// A request carries an opcode: absorb one data byte, finish, or start a
// new message. Digest words leave on the dig channel, word 0 first, with
// last_word set on word 7.
// The byte that completes a 64-byte block starts a compression (one
// round per cycle in a single shared round unit, plus start and
// fold-in). A finish pushes the padding one byte per cycle, pausing
// while a compression runs, and runs one or two compressions before
// the digest; the digest words then follow one per cycle while
// dig_stall is low. Data bytes are not accepted while a block
// compresses: msg_stall is high whenever the block is padding,
// compressing or sending a digest.
// A finish after a finish resends the same digest; data after a finish is
// dropped until a start request.
// Reset: hash words return to the initial values, byte counts clear and
// no digest is pending. If the receiver stalls, the current digest word
// holds on dig and the sequence resumes when dig_stall drops.
module sha256_message_hasher (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_valid,
	output logic             msg_stall,
	input  sha_pkg::msg_req_t msg,
	output logic             dig_valid,
	input  logic             dig_stall,
	output sha_pkg::dig_req_t dig
);
	import sha_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MARK  = 3'd1;
	localparam logic [2:0] S_ZERO  = 3'd2;
	localparam logic [2:0] S_LEN   = 3'd3;
	localparam logic [2:0] S_COMP  = 3'd4;
	localparam logic [2:0] S_EMIT0 = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0]         state_q;
	logic [2:0]         ret_q;
	hash_state_t        hash_q;
	logic [5:0]         count_q;
	logic [TOTAL_W-1:0] total_q;
	logic               fin_q;
	logic               start_q;
	logic [2:0]         len_idx_q;
	logic [2:0]         emit_idx_q;
	logic               dig_valid_q;

	core_ctrl_t  ctrl;
	core_stat_t  stat;
	hash_state_t work;

	logic        msg_take;
	logic        dig_take;
	logic [63:0] len_shift;
	logic [2:0]  load_idx;
	logic        load_out;

	assign msg_stall = (state_q != S_IDLE);
	assign msg_take  = msg_valid && !msg_stall;
	assign dig_take  = dig_valid_q && !dig_stall;
	assign dig_valid = dig_valid_q;

	// Length field byte, most significant first
	assign len_shift = {total_q, 3'b000} << {len_idx_q, 3'b000};

	// Byte pushed into the round unit's window
	always_comb begin
		ctrl.load  = 1'b0;
		ctrl.data  = '0;
		ctrl.start = start_q;
		unique case (state_q)
			S_IDLE: begin
				ctrl.load = msg_take && (msg.opcode == OP_DATA) && !fin_q;
				ctrl.data = msg.data_byte;
			end
			S_MARK: begin
				ctrl.load = 1'b1;
				ctrl.data = PAD_MARK_BYTE;
			end
			S_ZERO: begin
				ctrl.load = (count_q != LEN_POS);
			end
			S_LEN: begin
				ctrl.load = 1'b1;
				ctrl.data = len_shift[63:56];
			end
			default: begin
			end
		endcase
	end

	sha_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.hash_in (hash_q),
		.stat    (stat),
		.work    (work)
	);

	// Sequencer: message bookkeeping, padding and digest emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			hash_q      <= INIT_HASH;
			count_q     <= '0;
			total_q     <= '0;
			fin_q       <= 1'b0;
			start_q     <= 1'b0;
			len_idx_q   <= '0;
			emit_idx_q  <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (ctrl.load) begin
				count_q <= count_q + 6'd1;
				if (count_q == LAST_POS) begin
					start_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (msg_take) begin
						unique case (msg.opcode)
							OP_DATA: begin
								if (!fin_q) begin
									total_q <= total_q + TOTAL_W'(1);
									if (count_q == LAST_POS) begin
										state_q <= S_COMP;
										ret_q   <= S_IDLE;
									end
								end
							end
							OP_FINISH: begin
								state_q <= fin_q ? S_EMIT0 : S_MARK;
							end
							OP_START: begin
								hash_q  <= INIT_HASH;
								count_q <= '0;
								total_q <= '0;
								fin_q   <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				S_MARK: begin
					state_q <= (count_q == LAST_POS) ? S_COMP : S_ZERO;
					ret_q   <= S_ZERO;
				end
				S_ZERO: begin
					if (count_q == LEN_POS) begin
						state_q   <= S_LEN;
						len_idx_q <= '0;
					end else if (count_q == LAST_POS) begin
						state_q <= S_COMP;
						ret_q   <= S_ZERO;
					end
				end
				S_LEN: begin
					len_idx_q <= len_idx_q + 3'd1;
					if (len_idx_q == 3'd7) begin
						state_q <= S_COMP;
						ret_q   <= S_EMIT0;
						fin_q   <= 1'b1;
					end
				end
				S_COMP: begin
					if (stat.done) begin
						for (int i = 0; i < 8; i++) begin
							hash_q[i] <= hash_q[i] + work[i];
						end
						state_q <= ret_q;
					end
				end
				S_EMIT0: begin
					emit_idx_q  <= '0;
					dig_valid_q <= 1'b1;
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (dig_take) begin
						if (emit_idx_q == 3'd7) begin
							dig_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: next digest word
	assign load_idx = (state_q == S_EMIT0) ? 3'd0 : emit_idx_q + 3'd1;
	assign load_out = (state_q == S_EMIT0)
		|| ((state_q == S_EMIT) && dig_take && (emit_idx_q != 3'd7));

	always_ff @(posedge clk) begin
		if (load_out) begin
			dig.digest_word <= hash_q[load_idx];
			dig.word_index  <= load_idx;
			dig.last_word   <= (load_idx == 3'd7);
		end
	end

	// Requests are taken only while the round unit is quiet
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!msg_stall |-> !stat.busy)
		else $error("request taken while compression running");

	// A compression always begins on a block boundary
	a_start_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (count_q == 6'd0))
		else $error("compression started mid-block");

	// Completion only follows a running compression
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> $past(stat.busy))
		else $error("done without busy");

	// The digest sequence ends after its last word
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_take && dig.last_word) |=> !dig_valid)
		else $error("digest output continued past last word");

endmodule
